// ===== hw/rtl/triangle_cull_and_bound_macros.svh =====
// ----------------------------------------------------------------------------
// Triangle cull and bound assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_CULL_AND_BOUND_MACROS_SVH
`define TRIANGLE_CULL_AND_BOUND_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define TCB_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("port check failed");

// Consequent checked from the cycle after the antecedent.
`define TCB_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("port check failed");

`endif

// ===== hw/rtl/tcb_pkg.sv =====
// ----------------------------------------------------------------------------
// Triangle cull and bound package
// Payload types, register codes and helpers shared by the block's files.
// ----------------------------------------------------------------------------
`default_nettype none

package tcb_pkg;

   localparam int VERTEX_SLOTS_DEFAULT = 1024;
   localparam int COORD_BITS_DEFAULT   = 32;

   localparam int INDEX_BITS    = 10;
   localparam int FIELD_BITS    = 32;
   localparam int NORMAL_BITS   = 16;
   localparam int BOX_BITS      = 31;
   localparam int COUNT_BITS    = 16;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;
   localparam int REG_SEL_BITS  = 2;

   localparam logic [REG_SEL_BITS-1:0] REG_CAMERA_X       = 2'd0;
   localparam logic [REG_SEL_BITS-1:0] REG_CAMERA_Y       = 2'd1;
   localparam logic [REG_SEL_BITS-1:0] REG_CAMERA_Z       = 2'd2;
   localparam logic [REG_SEL_BITS-1:0] REG_TRIANGLE_COUNT = 2'd3;

   localparam logic OP_LOAD     = 1'b0;
   localparam logic OP_TRIANGLE = 1'b1;

   typedef struct packed {
      logic                          operation;
      logic [INDEX_BITS-1:0]         vertex_a;
      logic [INDEX_BITS-1:0]         vertex_b;
      logic [INDEX_BITS-1:0]         vertex_c;
      logic signed [FIELD_BITS-1:0]  world_x;
      logic signed [FIELD_BITS-1:0]  world_y;
      logic signed [FIELD_BITS-1:0]  world_z;
      logic signed [FIELD_BITS-1:0]  screen_x;
      logic signed [FIELD_BITS-1:0]  screen_y;
      logic signed [NORMAL_BITS-1:0] normal_x;
      logic signed [NORMAL_BITS-1:0] normal_y;
      logic signed [NORMAL_BITS-1:0] normal_z;
   } tcb_req_type;

   typedef struct packed {
      logic                  front_facing;
      logic [BOX_BITS-1:0]   box_x_min;
      logic [BOX_BITS-1:0]   box_y_min;
      logic [BOX_BITS-1:0]   box_x_max;
      logic [BOX_BITS-1:0]   box_y_max;
      logic [INDEX_BITS-1:0] index_a;
      logic [INDEX_BITS-1:0] index_b;
      logic [INDEX_BITS-1:0] index_c;
      logic                  last_in_batch;
   } tcb_rsp_type;

   // Strobes from the sequencer to the geometry datapath
   typedef struct packed {
      logic first;
      logic accumulate;
      logic multiply;
   } tcb_geom_ctl_type;

   function automatic int coord_width(input int coord_bits);
      return (coord_bits < FIELD_BITS) ? coord_bits : FIELD_BITS;
   endfunction

   // Vertex index modulo the slot count: compare and subtract, one shifted
   // multiple of the slot count per step.
   function automatic logic [INDEX_BITS-1:0] slot_reduce(
      input logic [INDEX_BITS-1:0] idx,
      input int                    slots
   );
      logic [INDEX_BITS-1:0] v;
      int                    lim;
      v = idx;
      for (int k = INDEX_BITS - 1; k >= 0; k--) begin
         lim = slots << k;
         if ((lim < (1 << INDEX_BITS)) && (int'(v) >= lim)) begin
            v = v - INDEX_BITS'(lim);
         end
      end
      return v;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tcb_vertex_mem.sv =====
// ----------------------------------------------------------------------------
// Vertex store
// Single-port synchronous memory, one vertex record per entry, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tcb_vertex_mem
   import tcb_pkg::*;
#(
   parameter int DEPTH     = VERTEX_SLOTS_DEFAULT,
   parameter int ADDR_BITS = 10,
   parameter int DATA_BITS = 208
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic                 we,
   input  logic [ADDR_BITS-1:0] addr,
   input  logic [DATA_BITS-1:0] wdata,
   output logic [DATA_BITS-1:0] rdata
);

   logic [DATA_BITS-1:0] mem_ff [DEPTH];
   logic [DATA_BITS-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/tcb_geom.sv =====
// ----------------------------------------------------------------------------
// Triangle geometry datapath
// Accumulates the centroid-to-camera vector, scaled by three, and the screen
// box over the three vertex reads, then tests facing on the first vertex normal.
// ----------------------------------------------------------------------------
`default_nettype none

module tcb_geom
   import tcb_pkg::*;
#(
   parameter int  COORD_BITS = COORD_BITS_DEFAULT,
   localparam int CW         = coord_width(COORD_BITS),
   localparam int VW         = 5 * CW + 3 * NORMAL_BITS
) (
   input  logic                  clock,
   input  tcb_geom_ctl_type      ctl,
   input  logic [VW-1:0]         vertex,
   input  logic signed [CW-1:0]  cam_x,
   input  logic signed [CW-1:0]  cam_y,
   input  logic signed [CW-1:0]  cam_z,
   output logic                  front_facing,
   output logic [BOX_BITS-1:0]   box_x_min,
   output logic [BOX_BITS-1:0]   box_y_min,
   output logic [BOX_BITS-1:0]   box_x_max,
   output logic [BOX_BITS-1:0]   box_y_max
);

   localparam int DW = CW + 3;
   localparam int PW = DW + NORMAL_BITS;
   localparam int SW = PW + 2;

   logic signed [CW-1:0]          wx, wy, wz, sx, sy;
   logic signed [NORMAL_BITS-1:0] nx, ny, nz;

   logic signed [DW-1:0] cam3_x_ff, cam3_y_ff, cam3_z_ff;
   logic signed [DW-1:0] cam3_x_in, cam3_y_in, cam3_z_in;
   logic signed [DW-1:0] d_x_ff, d_y_ff, d_z_ff;
   logic signed [DW-1:0] d_x_in, d_y_in, d_z_in;
   logic signed [NORMAL_BITS-1:0] n_x_ff, n_y_ff, n_z_ff;
   logic signed [NORMAL_BITS-1:0] n_x_in, n_y_in, n_z_in;
   logic signed [CW-1:0] x_min_ff, x_max_ff, y_min_ff, y_max_ff;
   logic signed [CW-1:0] x_min_in, x_max_in, y_min_in, y_max_in;
   logic signed [PW-1:0] p_x_ff, p_y_ff, p_z_ff;
   logic signed [PW-1:0] p_x_in, p_y_in, p_z_in;
   logic signed [SW-1:0] dot;

   function automatic logic [BOX_BITS-1:0] clamp_edge(input logic signed [CW-1:0] v);
      if (v[CW-1]) begin
         return '0;
      end
      return BOX_BITS'(v[CW-2:0]);
   endfunction

   assign wx = vertex[CW-1:0];
   assign wy = vertex[2*CW-1:CW];
   assign wz = vertex[3*CW-1:2*CW];
   assign sx = vertex[4*CW-1:3*CW];
   assign sy = vertex[5*CW-1:4*CW];
   assign nx = vertex[5*CW+NORMAL_BITS-1:5*CW];
   assign ny = vertex[5*CW+2*NORMAL_BITS-1:5*CW+NORMAL_BITS];
   assign nz = vertex[5*CW+3*NORMAL_BITS-1:5*CW+2*NORMAL_BITS];

   // Three times the camera, kept ready ahead of the first vertex
   assign cam3_x_in = DW'(cam_x) + (DW'(cam_x) <<< 1);
   assign cam3_y_in = DW'(cam_y) + (DW'(cam_y) <<< 1);
   assign cam3_z_in = DW'(cam_z) + (DW'(cam_z) <<< 1);

   always_comb begin
      d_x_in   = d_x_ff;
      d_y_in   = d_y_ff;
      d_z_in   = d_z_ff;
      n_x_in   = n_x_ff;
      n_y_in   = n_y_ff;
      n_z_in   = n_z_ff;
      x_min_in = x_min_ff;
      x_max_in = x_max_ff;
      y_min_in = y_min_ff;
      y_max_in = y_max_ff;
      if (ctl.first) begin
         d_x_in   = cam3_x_ff - DW'(wx);
         d_y_in   = cam3_y_ff - DW'(wy);
         d_z_in   = cam3_z_ff - DW'(wz);
         n_x_in   = nx;
         n_y_in   = ny;
         n_z_in   = nz;
         x_min_in = sx;
         x_max_in = sx;
         y_min_in = sy;
         y_max_in = sy;
      end else if (ctl.accumulate) begin
         d_x_in = d_x_ff - DW'(wx);
         d_y_in = d_y_ff - DW'(wy);
         d_z_in = d_z_ff - DW'(wz);
         if (sx < x_min_ff) begin
            x_min_in = sx;
         end
         if (sx > x_max_ff) begin
            x_max_in = sx;
         end
         if (sy < y_min_ff) begin
            y_min_in = sy;
         end
         if (sy > y_max_ff) begin
            y_max_in = sy;
         end
      end
   end

   always_comb begin
      p_x_in = p_x_ff;
      p_y_in = p_y_ff;
      p_z_in = p_z_ff;
      if (ctl.multiply) begin
         p_x_in = PW'(d_x_ff) * PW'(n_x_ff);
         p_y_in = PW'(d_y_ff) * PW'(n_y_ff);
         p_z_in = PW'(d_z_ff) * PW'(n_z_ff);
      end
   end

   always_ff @(posedge clock) begin
      cam3_x_ff <= cam3_x_in;
      cam3_y_ff <= cam3_y_in;
      cam3_z_ff <= cam3_z_in;
      d_x_ff    <= d_x_in;
      d_y_ff    <= d_y_in;
      d_z_ff    <= d_z_in;
      n_x_ff    <= n_x_in;
      n_y_ff    <= n_y_in;
      n_z_ff    <= n_z_in;
      x_min_ff  <= x_min_in;
      x_max_ff  <= x_max_in;
      y_min_ff  <= y_min_in;
      y_max_ff  <= y_max_in;
      p_x_ff    <= p_x_in;
      p_y_ff    <= p_y_in;
      p_z_ff    <= p_z_in;
   end

   assign dot          = SW'(p_x_ff) + SW'(p_y_ff) + SW'(p_z_ff);
   assign front_facing = !dot[SW-1] && (dot != '0);
   assign box_x_min    = clamp_edge(x_min_ff);
   assign box_y_min    = clamp_edge(y_min_ff);
   assign box_x_max    = clamp_edge(x_max_ff);
   assign box_y_max    = clamp_edge(y_max_ff);

endmodule

`default_nettype wire

// ===== hw/rtl/triangle_cull_and_bound.sv =====
// ----------------------------------------------------------------------------
// Triangle cull and bound
// Load items (operation 0) write one vertex record into the vertex store;
// triangle items (operation 1) read vertices a, b and c, test facing against
// the camera and return one result with the clamped screen box, or a zero
// box when culled. Loads give no result.
// Both channels transfer when valid is high and stall is low. A load does not
// hold up the block. A triangle occupies it from acceptance, which reads a from
// the single-port vertex store, through FETCH_B and FETCH_C, which read b and c,
// TAKE_C, which takes in c, MUL, which multiplies by the normal, and DONE, which
// sums and registers the result for rsp. The next item is taken in DONE while
// the output register is free, so a new triangle starts as a result is written.
// A stalled result holds in the output register; a following load is still
// taken, a following triangle waits in DONE until the result moves.
// Reset (synchronous) clears the sequencer, the output valid and the batch
// counter and sets the registers to camera 0 and count 1; the vertex store
// is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_cull_and_bound
   import tcb_pkg::*;
#(
   parameter int VERTEX_SLOTS = VERTEX_SLOTS_DEFAULT,
   parameter int COORD_BITS   = COORD_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  tcb_req_type              req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output tcb_rsp_type              rsp_data,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   localparam int CW = coord_width(COORD_BITS);
   localparam int AW = (VERTEX_SLOTS > 1) ? $clog2(VERTEX_SLOTS) : 1;
   localparam int VW = 5 * CW + 3 * NORMAL_BITS;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_FETCH_B = 3'd1;
   localparam logic [2:0] ST_FETCH_C = 3'd2;
   localparam logic [2:0] ST_TAKE_C  = 3'd3;
   localparam logic [2:0] ST_MUL     = 3'd4;
   localparam logic [2:0] ST_DONE    = 3'd5;

   logic [2:0] state_ff, state_in;

   logic [FIELD_BITS-1:0] cam_x_ff, cam_y_ff, cam_z_ff;
   logic [FIELD_BITS-1:0] cam_x_in, cam_y_in, cam_z_in;
   logic [COUNT_BITS-1:0] tri_count_ff, tri_count_in;
   logic [COUNT_BITS-1:0] batch_cnt_ff, batch_cnt_in, batch_step;
   logic                  batch_last;

   logic [INDEX_BITS-1:0] idx_a_ff, idx_b_ff, idx_c_ff;
   logic [INDEX_BITS-1:0] idx_a_in, idx_b_in, idx_c_in;
   logic [AW-1:0]         slot_b_ff, slot_c_ff, slot_b_in, slot_c_in, slot_a;

   logic        rsp_valid_ff, rsp_valid_in;
   tcb_rsp_type rsp_ff, rsp_in;

   logic open_slot, accept, accept_tri, out_free, out_write;
   logic csr_write;
   logic [REG_SEL_BITS-1:0] reg_sel;

   logic          mem_en, mem_we;
   logic [AW-1:0] mem_addr;
   logic [VW-1:0] mem_wdata, mem_rdata;

   tcb_geom_ctl_type    geom_ctl;
   logic                front;
   logic [BOX_BITS-1:0] bx_min, by_min, bx_max, by_max;

   // Handshake and sequencing
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign open_slot  = (state_ff == ST_IDLE) || ((state_ff == ST_DONE) && out_free);
   assign req_stall  = !open_slot;
   assign accept     = req_valid && open_slot;
   assign accept_tri = accept && (req_data.operation == OP_TRIANGLE);
   assign out_write  = (state_ff == ST_DONE) && out_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept_tri) begin
               state_in = ST_FETCH_B;
            end
         end
         ST_FETCH_B: state_in = ST_FETCH_C;
         ST_FETCH_C: state_in = ST_TAKE_C;
         ST_TAKE_C:  state_in = ST_MUL;
         ST_MUL:     state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = accept_tri ? ST_FETCH_B : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Capture indices on acceptance; slots of b and c are resolved up front
   assign slot_a = AW'(slot_reduce(req_data.vertex_a, VERTEX_SLOTS));

   always_comb begin
      idx_a_in  = idx_a_ff;
      idx_b_in  = idx_b_ff;
      idx_c_in  = idx_c_ff;
      slot_b_in = slot_b_ff;
      slot_c_in = slot_c_ff;
      if (accept_tri) begin
         idx_a_in  = req_data.vertex_a;
         idx_b_in  = req_data.vertex_b;
         idx_c_in  = req_data.vertex_c;
         slot_b_in = AW'(slot_reduce(req_data.vertex_b, VERTEX_SLOTS));
         slot_c_in = AW'(slot_reduce(req_data.vertex_c, VERTEX_SLOTS));
      end
   end

   // Vertex store port: load write or read of a at acceptance, then b and c
   assign mem_en = accept || (state_ff == ST_FETCH_B) || (state_ff == ST_FETCH_C);
   assign mem_we = accept && (req_data.operation == OP_LOAD);

   always_comb begin
      case (state_ff)
         ST_FETCH_B: mem_addr = slot_b_ff;
         ST_FETCH_C: mem_addr = slot_c_ff;
         default:    mem_addr = slot_a;
      endcase
   end

   assign mem_wdata = {req_data.normal_z, req_data.normal_y, req_data.normal_x,
                       req_data.screen_y[CW-1:0], req_data.screen_x[CW-1:0],
                       req_data.world_z[CW-1:0], req_data.world_y[CW-1:0],
                       req_data.world_x[CW-1:0]};

   tcb_vertex_mem #(
      .DEPTH     (VERTEX_SLOTS),
      .ADDR_BITS (AW),
      .DATA_BITS (VW)
   ) u_vertex_mem (
      .clock (clock),
      .en    (mem_en),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   assign geom_ctl.first      = (state_ff == ST_FETCH_B);
   assign geom_ctl.accumulate = (state_ff == ST_FETCH_C) || (state_ff == ST_TAKE_C);
   assign geom_ctl.multiply   = (state_ff == ST_MUL);

   tcb_geom #(
      .COORD_BITS (COORD_BITS)
   ) u_geom (
      .clock        (clock),
      .ctl          (geom_ctl),
      .vertex       (mem_rdata),
      .cam_x        (cam_x_ff[CW-1:0]),
      .cam_y        (cam_y_ff[CW-1:0]),
      .cam_z        (cam_z_ff[CW-1:0]),
      .front_facing (front),
      .box_x_min    (bx_min),
      .box_y_min    (by_min),
      .box_x_max    (bx_max),
      .box_y_max    (by_max)
   );

   // Batch counter: wrap to zero on the triangle that completes the count
   assign batch_step = batch_cnt_ff + COUNT_BITS'(1);
   assign batch_last = (batch_step == '0) || (batch_step >= tri_count_ff);

   always_comb begin
      batch_cnt_in = batch_cnt_ff;
      if (out_write) begin
         batch_cnt_in = batch_last ? '0 : batch_step;
      end
   end

   // Output register
   assign rsp_valid_in = (rsp_valid_ff && rsp_stall) || out_write;

   always_comb begin
      rsp_in = rsp_ff;
      if (out_write) begin
         rsp_in.front_facing  = front;
         rsp_in.box_x_min     = front ? bx_min : '0;
         rsp_in.box_y_min     = front ? by_min : '0;
         rsp_in.box_x_max     = front ? bx_max : '0;
         rsp_in.box_y_max     = front ? by_max : '0;
         rsp_in.index_a       = idx_a_ff;
         rsp_in.index_b       = idx_b_ff;
         rsp_in.index_c       = idx_c_ff;
         rsp_in.last_in_batch = batch_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Register port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign reg_sel   = paddr[CSR_ADDR_BITS-1:2];

   always_comb begin
      cam_x_in     = cam_x_ff;
      cam_y_in     = cam_y_ff;
      cam_z_in     = cam_z_ff;
      tri_count_in = tri_count_ff;
      if (csr_write) begin
         case (reg_sel)
            REG_CAMERA_X:       cam_x_in     = pwdata;
            REG_CAMERA_Y:       cam_y_in     = pwdata;
            REG_CAMERA_Z:       cam_z_in     = pwdata;
            REG_TRIANGLE_COUNT: tri_count_in = pwdata[COUNT_BITS-1:0];
            default:            tri_count_in = tri_count_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_CAMERA_X:       prdata = cam_x_ff;
         REG_CAMERA_Y:       prdata = cam_y_ff;
         REG_CAMERA_Z:       prdata = cam_z_ff;
         REG_TRIANGLE_COUNT: prdata = CSR_DATA_BITS'(tri_count_ff);
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         batch_cnt_ff <= '0;
         cam_x_ff     <= '0;
         cam_y_ff     <= '0;
         cam_z_ff     <= '0;
         tri_count_ff <= COUNT_BITS'(1);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         batch_cnt_ff <= batch_cnt_in;
         cam_x_ff     <= cam_x_in;
         cam_y_ff     <= cam_y_in;
         cam_z_ff     <= cam_z_in;
         tri_count_ff <= tri_count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_a_ff  <= idx_a_in;
      idx_b_ff  <= idx_b_in;
      idx_c_ff  <= idx_c_in;
      slot_b_ff <= slot_b_in;
      slot_c_ff <= slot_c_in;
      rsp_ff    <= rsp_in;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/tcb_port_checker.sv =====
// ----------------------------------------------------------------------------
// Triangle cull and bound port checker
// Watches the item channels of the top level and flags broken behavior.
// ----------------------------------------------------------------------------
`default_nettype none

`include "triangle_cull_and_bound_macros.svh"

module tcb_port_checker
   import tcb_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input tcb_req_type req_data,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input tcb_rsp_type rsp_data
);

   logic load_xfer, tri_xfer, culled, box_zero;

   assign load_xfer = req_valid && !req_stall && (req_data.operation == OP_LOAD);
   assign tri_xfer  = req_valid && !req_stall && (req_data.operation == OP_TRIANGLE);
   assign culled    = rsp_valid && !rsp_data.front_facing;
   assign box_zero  = (rsp_data.box_x_min == '0) && (rsp_data.box_y_min == '0)
                      && (rsp_data.box_x_max == '0) && (rsp_data.box_y_max == '0);

   // A load never blocks the next transfer
   `TCB_ASSERT_NEXT(a_load_then_ready, load_xfer, !req_stall)

   // A triangle holds the input while it reads b and c, takes in c and multiplies
   `TCB_ASSERT_NEXT(a_triangle_busy, tri_xfer, req_stall ##1 req_stall ##1 req_stall ##1 req_stall)

   // Culled triangles report an empty box
   `TCB_ASSERT_SAME(a_culled_box_zero, culled, box_zero)

   `TCB_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

endmodule

bind triangle_cull_and_bound tcb_port_checker u_port_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
